// ===== src/text_console_writer_defines.svh =====
// ----------------------------------------------------------------------------
// text_console_writer_defines
// Assertion macros used by the console RTL.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

`ifndef ASSERT_OFF
// antecedent holds -> consequent holds in the same cycle
`define TCW_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tcw assertion failed");
// antecedent holds -> consequent holds in the next cycle
`define TCW_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tcw assertion failed");
`else
`define TCW_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define TCW_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== src/tcw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Types and fixed constants of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int OP_W     = 2;
    localparam int BYTE_W   = 8;
    localparam int INDEX_W  = 11;

    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [BYTE_W-1:0] SPACE_CODE   = 8'h20;
    localparam logic [BYTE_W-1:0] ATTR_RESET   = 8'h0F;
    localparam logic [BYTE_W-1:0] ATTR_CLEAR   = 8'h00;

    typedef struct packed {
        logic [BYTE_W-1:0] attr;
        logic [BYTE_W-1:0] code;
    } cell_t;

    localparam int CELL_W = $bits(cell_t);

endpackage

// ===== src/text_console_writer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer
// Text console of ROWS x COLUMNS cells with cursor, scroll, clear and read.
// ----------------------------------------------------------------------------
// From accept to out_valid: a plain put goes straight to RESP, a put that scrolls
// and a clear first run a write sweep through the one RAM write port, a read waits
// in RDWT. in_stall is high while busy, so no new item is taken until the last is out.
// Scrolling rotates a row base register and zero-fills only the new bottom row.
// After reset a clearing pass over all ROWS*COLUMNS cells zeroes the screen RAM;
// in_stall stays high during it. Cursor resets to 0, attribute to 0x0F.
// ----------------------------------------------------------------------------
`include "text_console_writer_defines.svh"

module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [tcw_pkg::OP_W-1:0]          operation,
    input  logic [tcw_pkg::BYTE_W-1:0]        character_code,
    input  logic [tcw_pkg::INDEX_W-1:0]       cell_index,
    // output channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [tcw_pkg::INDEX_W-1:0]       cursor_position,
    output logic [tcw_pkg::BYTE_W-1:0]        read_character,
    output logic [tcw_pkg::BYTE_W-1:0]        read_attribute,
    // attribute register
    input  logic                              cfg_wr_en,
    input  logic [tcw_pkg::BYTE_W-1:0]        cfg_wr_data
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int IDX_W      = (ADDR_W > tcw_pkg::INDEX_W) ? ADDR_W : tcw_pkg::INDEX_W;

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RDWT  = 3'd2;
    localparam logic [2:0] ST_SWEEP = 3'd3;
    localparam logic [2:0] ST_RESP  = 3'd4;

    logic [2:0]                 state_reg, state_next;
    logic [ADDR_W-1:0]          cursor_reg, cursor_next;
    logic [COL_W-1:0]           col_reg, col_next;
    logic [ADDR_W-1:0]          base_reg, base_next;
    logic [ADDR_W-1:0]          sweep_addr_reg, sweep_addr_next;
    logic [ADDR_W-1:0]          sweep_left_reg, sweep_left_next;
    tcw_pkg::cell_t             fill_reg, fill_next;
    logic [tcw_pkg::BYTE_W-1:0] attr_reg, attr_next;
    logic [tcw_pkg::BYTE_W-1:0] res_code_reg, res_code_next;
    logic [tcw_pkg::BYTE_W-1:0] res_attr_reg, res_attr_next;
    logic                       out_valid_reg, out_valid_next;
    logic [tcw_pkg::INDEX_W-1:0] out_cursor_reg, out_cursor_next;
    logic [tcw_pkg::BYTE_W-1:0] out_code_reg, out_code_next;
    logic [tcw_pkg::BYTE_W-1:0] out_attr_reg, out_attr_next;

    logic                       mem_we;
    logic [ADDR_W-1:0]          mem_waddr;
    tcw_pkg::cell_t             mem_wdata;
    logic [ADDR_W-1:0]          mem_raddr;
    tcw_pkg::cell_t             mem_rdata;

    logic                       in_accept;
    logic                       out_free;
    logic [ADDR_W:0]            cur_sum, rd_sum, base_sum;
    logic [ADDR_W-1:0]          cur_phys, rd_phys, base_wrap;
    logic [IDX_W-1:0]           idx_ext, cursor_ext;
    logic                       idx_in_range;
    logic [ADDR_W-1:0]          row_start;
    logic [ADDR_W:0]            nl_target, inc_target;
    logic                       nl_scroll, inc_scroll;

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_screen (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // logical cell -> physical RAM cell through the rotating row base
    assign cur_sum  = {1'b0, cursor_reg} + {1'b0, base_reg};
    assign cur_phys = (cur_sum >= (ADDR_W+1)'(CELL_COUNT)) ?
                      ADDR_W'(cur_sum - (ADDR_W+1)'(CELL_COUNT)) : cur_sum[ADDR_W-1:0];

    assign idx_ext      = IDX_W'(cell_index);
    assign idx_in_range = (idx_ext <= IDX_W'(CELL_COUNT - 1));
    assign rd_sum  = {1'b0, idx_ext[ADDR_W-1:0]} + {1'b0, base_reg};
    assign rd_phys = (rd_sum >= (ADDR_W+1)'(CELL_COUNT)) ?
                     ADDR_W'(rd_sum - (ADDR_W+1)'(CELL_COUNT)) : rd_sum[ADDR_W-1:0];

    assign base_sum  = {1'b0, base_reg} + (ADDR_W+1)'(COLUMNS);
    assign base_wrap = (base_sum >= (ADDR_W+1)'(CELL_COUNT)) ? '0 : base_sum[ADDR_W-1:0];

    assign row_start  = cursor_reg - ADDR_W'(col_reg);
    assign nl_target  = {1'b0, row_start} + (ADDR_W+1)'(COLUMNS);
    assign nl_scroll  = (nl_target >= (ADDR_W+1)'(CELL_COUNT));
    assign inc_target = {1'b0, cursor_reg} + (ADDR_W+1)'(1);
    assign inc_scroll = (inc_target >= (ADDR_W+1)'(CELL_COUNT));

    assign cursor_ext = IDX_W'(cursor_reg);
    assign mem_raddr  = rd_phys;

    always_comb
    begin
        state_next      = state_reg;
        cursor_next     = cursor_reg;
        col_next        = col_reg;
        base_next       = base_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_left_next = sweep_left_reg;
        fill_next       = fill_reg;
        attr_next       = cfg_wr_en ? cfg_wr_data : attr_reg;
        res_code_next   = res_code_reg;
        res_attr_next   = res_attr_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_cursor_next = out_cursor_reg;
        out_code_next   = out_code_reg;
        out_attr_next   = out_attr_reg;
        mem_we          = 1'b0;
        mem_waddr       = sweep_addr_reg;
        mem_wdata       = fill_reg;

        unique case (state_reg)
            ST_INIT, ST_SWEEP:
            begin
                mem_we          = 1'b1;
                sweep_addr_next = sweep_addr_reg + ADDR_W'(1);
                sweep_left_next = sweep_left_reg - ADDR_W'(1);
                if (sweep_left_reg == '0)
                begin
                    state_next = (state_reg == ST_INIT) ? ST_IDLE : ST_RESP;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    res_code_next = '0;
                    res_attr_next = '0;
                    state_next    = ST_RESP;
                    unique case (operation)
                        tcw_pkg::OP_PUT:
                        begin
                            if (character_code != tcw_pkg::NEWLINE_CODE)
                            begin
                                mem_we          = 1'b1;
                                mem_waddr       = cur_phys;
                                mem_wdata.code  = character_code;
                                mem_wdata.attr  = attr_reg;
                            end
                            if ((character_code == tcw_pkg::NEWLINE_CODE) ? nl_scroll : inc_scroll)
                            begin
                                // scroll: old top row becomes the new, zeroed bottom row
                                cursor_next     = ADDR_W'(CELL_COUNT - COLUMNS);
                                col_next        = '0;
                                sweep_addr_next = base_reg;
                                sweep_left_next = ADDR_W'(COLUMNS - 1);
                                fill_next       = '0;
                                base_next       = base_wrap;
                                state_next      = ST_SWEEP;
                            end
                            else if (character_code == tcw_pkg::NEWLINE_CODE)
                            begin
                                cursor_next = nl_target[ADDR_W-1:0];
                                col_next    = '0;
                            end
                            else
                            begin
                                cursor_next = inc_target[ADDR_W-1:0];
                                col_next    = (col_reg == COL_W'(COLUMNS - 1)) ?
                                              '0 : col_reg + COL_W'(1);
                            end
                        end
                        tcw_pkg::OP_CLEAR:
                        begin
                            sweep_addr_next = '0;
                            sweep_left_next = ADDR_W'(CELL_COUNT - 1);
                            fill_next.code  = tcw_pkg::SPACE_CODE;
                            fill_next.attr  = tcw_pkg::ATTR_CLEAR;
                            state_next      = ST_SWEEP;
                        end
                        tcw_pkg::OP_READ:
                        begin
                            if (idx_in_range)
                            begin
                                state_next = ST_RDWT;
                            end
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_RDWT:
            begin
                res_code_next = mem_rdata.code;
                res_attr_next = mem_rdata.attr;
                state_next    = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_cursor_next = cursor_ext[tcw_pkg::INDEX_W-1:0];
                    out_code_next   = res_code_reg;
                    out_attr_next   = res_attr_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            cursor_reg     <= '0;
            col_reg        <= '0;
            base_reg       <= '0;
            sweep_addr_reg <= '0;
            sweep_left_reg <= ADDR_W'(CELL_COUNT - 1);
            fill_reg       <= '0;
            attr_reg       <= tcw_pkg::ATTR_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cursor_reg     <= cursor_next;
            col_reg        <= col_next;
            base_reg       <= base_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_left_reg <= sweep_left_next;
            fill_reg       <= fill_next;
            attr_reg       <= attr_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_code_reg   <= res_code_next;
        res_attr_reg   <= res_attr_next;
        out_cursor_reg <= out_cursor_next;
        out_code_reg   <= out_code_next;
        out_attr_reg   <= out_attr_next;
    end

    assign out_valid       = out_valid_reg;
    assign cursor_position = out_cursor_reg;
    assign read_character  = out_code_reg;
    assign read_attribute  = out_attr_reg;

    `TCW_ASSERT_IMP(a_cursor_range, clk, rst_n, 1'b1, cursor_reg <= ADDR_W'(CELL_COUNT - 1))
    `TCW_ASSERT_IMP(a_col_matches, clk, rst_n, 1'b1, (col_reg <= COL_W'(COLUMNS - 1)) && (row_start <= cursor_reg))
    `TCW_ASSERT_IMP(a_base_range, clk, rst_n, 1'b1, base_reg <= ADDR_W'(CELL_COUNT - COLUMNS))
    `TCW_ASSERT_IMP(a_no_write_on_read, clk, rst_n, state_reg == ST_RDWT || state_reg == ST_RESP, !mem_we)
    `TCW_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_accept, in_stall)

endmodule

// ===== src/tcw_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
